// ===== design/gbol_pkg.sv =====
// shared constants, types and helpers of the grid block owner lookup
`default_nettype none
package gbol_pkg;

    localparam int MAX_PROCS   = 64;
    localparam int COORD_BITS  = 24;
    localparam int NUM_AXES    = 3;
    localparam int SLOT_W      = $clog2(MAX_PROCS);
    localparam int SLOT_IN_W   = 6;
    localparam int PROCS_W     = 7;
    localparam int DIMS_W      = 2;
    localparam int AXIS_W      = 2;
    localparam int CELLS_W     = 24;
    localparam int RANK_W      = 18;
    localparam int TABLE_DEPTH = NUM_AXES * MAX_PROCS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CELLS_W-1:0]    t_cells;
    typedef logic [SLOT_IN_W-1:0]  t_slot_in;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [PROCS_W-1:0]    t_procs;
    typedef logic [AXIS_W-1:0]     t_axis;
    typedef logic [DIMS_W-1:0]     t_dims;
    typedef logic [RANK_W-1:0]     t_rank;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    localparam t_cfg_idx CFG_DIMS    = 2'd0;
    localparam t_cfg_idx CFG_PROCS_X = 2'd1;
    localparam t_cfg_idx CFG_PROCS_Y = 2'd2;
    localparam t_cfg_idx CFG_PROCS_Z = 2'd3;

    localparam t_coord COORD_MAX = {COORD_BITS{1'b1}};

    // slab indices and counts handed to the rank unit
    typedef struct packed {
        t_slot  s_x;
        t_slot  s_y;
        t_slot  s_z;
        t_procs n_x;
        t_procs n_y;
    } t_rank_req;

    // zero counts as one slab, anything above the table size as the table size
    function automatic t_procs clamp_procs(input t_procs n);
        t_procs res;
        res = n;
        if (n == '0) begin
            res = PROCS_W'(1);
        end else if (n > PROCS_W'(MAX_PROCS)) begin
            res = PROCS_W'(MAX_PROCS);
        end
        return res;
    endfunction

    function automatic t_addr table_addr(input t_axis axis, input t_slot slot);
        return t_addr'(ADDR_W'(axis) * ADDR_W'(MAX_PROCS)) + t_addr'(slot);
    endfunction

endpackage
`default_nettype wire

// ===== design/gbol_in_if.sv =====
// input channel: load and query items
`default_nettype none
interface gbol_in_if;
    import gbol_pkg::*;

    logic     valid;
    logic     ready;
    logic     mode;
    t_axis    axis;
    t_slot_in slot;
    t_cells   slab_cells;
    t_coord   coord_x;
    t_coord   coord_y;
    t_coord   coord_z;

    modport source (
        output valid, mode, axis, slot, slab_cells, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, mode, axis, slot, slab_cells, coord_x, coord_y, coord_z,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/gbol_out_if.sv =====
// output channel: owner rank results
`default_nettype none
interface gbol_out_if;
    import gbol_pkg::*;

    logic  valid;
    logic  ready;
    t_rank owner_rank;
    logic  not_found;

    modport source (
        output valid, owner_rank, not_found,
        input  ready
    );
    modport sink (
        input  valid, owner_rank, not_found,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/gbol_bnd_ram.sv =====
// simple dual port ram holding the slab boundaries, registered read
`default_nettype none
module gbol_bnd_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== design/gbol_rank.sv =====
// row-major rank from slab indices, three register stages
`default_nettype none
module gbol_rank (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire gbol_pkg::t_rank_req i_req,
    output      logic                o_done,
    output      gbol_pkg::t_rank     o_rank
);
    import gbol_pkg::*;

    localparam int P1_W  = SLOT_W + PROCS_W;
    localparam int NN_W  = 2 * PROCS_W;
    localparam int P2_W  = SLOT_W + NN_W;
    localparam int SUM_W = P2_W + 1;

    logic              r_v1, r_v2, r_v3;
    logic [P1_W-1:0]   r_p1;
    logic [NN_W-1:0]   r_nn;
    t_slot             r_sx1, r_sz1;
    logic [SUM_W-1:0]  r_part;
    logic [P2_W-1:0]   r_p2;
    t_rank             r_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p1  <= P1_W'(i_req.s_y) * P1_W'(i_req.n_x);
            r_nn  <= NN_W'(i_req.n_x) * NN_W'(i_req.n_y);
            r_sx1 <= i_req.s_x;
            r_sz1 <= i_req.s_z;
        end
        if (r_v1) begin
            r_p2   <= P2_W'(r_sz1) * P2_W'(r_nn);
            r_part <= SUM_W'(r_sx1) + SUM_W'(r_p1);
        end
        if (r_v2) begin
            r_rank <= RANK_W'(r_part + SUM_W'(r_p2));
        end
    end

    assign o_done = r_v3;
    assign o_rank = r_rank;
endmodule
`default_nettype wire

// ===== design/grid_block_owner_lookup_core.sv =====
// grid block owner lookup: boundary table, slab scan and result channel
// load: from transfer back to ready, read the previous boundary, then add and write
// query: per active axis one boundary read per cycle from the table ram, compared
//   in the next cycle once the registered read returns; then the rank unit and the
//   hand-off to the output register, one item at a time
// reset (synchronous, active low) clears control state and sets dims and slab counts
//   to 1; the boundary table is not cleared and is undefined until loaded
`default_nettype none
module grid_block_owner_lookup_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    gbol_in_if.sink                    i_in,
    gbol_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire gbol_pkg::t_cfg_idx    i_cfg_idx,
    input  wire gbol_pkg::t_cfg_data   i_cfg_data
);
    import gbol_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LD_RD = 6'b000010,
        S_LD_WR = 6'b000100,
        S_SCAN  = 6'b001000,
        S_RANK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;

    // configuration registers
    t_dims  r_dims;
    t_procs r_px, r_py, r_pz;

    // captured item
    t_axis    r_axis_ld;
    t_slot    r_slot;
    t_cells   r_cells;
    t_coord   r_cx, r_cy, r_cz;

    // scan state
    t_axis  r_sax;
    t_procs r_idx;
    logic   r_pend;
    t_slot  r_pidx;
    t_slot  r_sx, r_sy, r_sz;
    logic   r_nf;
    logic   r_go;

    // output register
    logic   r_out_valid;
    t_rank  r_out_rank;
    logic   r_out_nf;

    // ram ports
    logic   w_we, w_re;
    t_addr  w_waddr, w_raddr;
    t_coord w_wdata, w_rdata;

    // rank unit
    t_rank_req w_req;
    logic      w_rank_done;
    t_rank     w_rank;

    logic      w_in_xfer, w_out_xfer, w_out_free;
    t_axis     w_last_axis;
    t_procs    w_n_cur;
    t_coord    w_coord_cur;
    logic      w_hit, w_miss_end, w_adv, w_issue;
    t_procs    w_n_x, w_n_y, w_n_z;
    t_coord    w_base;
    logic [COORD_BITS:0] w_sum;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = r_out_valid && o_out.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_n_x = clamp_procs(r_px);
    assign w_n_y = clamp_procs(r_py);
    assign w_n_z = clamp_procs(r_pz);

    // dims of zero behaves as one axis
    assign w_last_axis = (r_dims == '0) ? AXIS_X : t_axis'(r_dims - DIMS_W'(1));

    always_comb begin
        case (r_sax)
            AXIS_X: begin
                w_n_cur     = w_n_x;
                w_coord_cur = r_cx;
            end
            AXIS_Y: begin
                w_n_cur     = w_n_y;
                w_coord_cur = r_cy;
            end
            AXIS_Z: begin
                w_n_cur     = w_n_z;
                w_coord_cur = r_cz;
            end
            default: begin
                w_n_cur     = w_n_x;
                w_coord_cur = r_cx;
            end
        endcase
    end

    // first boundary above the coordinate ends the axis; running off the last
    // slab ends it too and marks the query not found
    assign w_hit      = (r_state == S_SCAN) && r_pend && (w_rdata > w_coord_cur);
    assign w_miss_end = (r_state == S_SCAN) && r_pend && !w_hit &&
                        (t_procs'(r_pidx) == w_n_cur - PROCS_W'(1));
    assign w_adv      = w_hit || w_miss_end;
    assign w_issue    = (r_state == S_SCAN) && !w_adv && (r_idx < w_n_cur);

    // read port: previous boundary on a load, next boundary while scanning
    always_comb begin
        w_re    = 1'b0;
        w_raddr = table_addr(r_sax, r_idx[SLOT_W-1:0]);
        if (r_state == S_LD_RD) begin
            w_re    = (r_slot != '0);
            w_raddr = table_addr(r_axis_ld, r_slot - SLOT_W'(1));
        end else if (w_issue) begin
            w_re = 1'b1;
        end
    end

    // boundary of the new slab, saturated at the top of the coordinate range
    assign w_base  = (r_slot == '0) ? '0 : w_rdata;
    assign w_sum   = {1'b0, w_base} + (COORD_BITS + 1)'(r_cells);
    assign w_we    = (r_state == S_LD_WR);
    assign w_waddr = table_addr(r_axis_ld, r_slot);
    assign w_wdata = w_sum[COORD_BITS] ? COORD_MAX : w_sum[COORD_BITS-1:0];

    gbol_bnd_ram #(
        .WIDTH  (COORD_BITS),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_req.s_x = r_sx;
    assign w_req.s_y = r_sy;
    assign w_req.s_z = r_sz;
    assign w_req.n_x = w_n_x;
    assign w_req.n_y = w_n_y;

    gbol_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_req   (w_req),
        .o_done  (w_rank_done),
        .o_rank  (w_rank)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(1);
            r_px   <= PROCS_W'(1);
            r_py   <= PROCS_W'(1);
            r_pz   <= PROCS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIMS:    r_dims <= i_cfg_data[DIMS_W-1:0];
                CFG_PROCS_X: r_px   <= i_cfg_data[PROCS_W-1:0];
                CFG_PROCS_Y: r_py   <= i_cfg_data[PROCS_W-1:0];
                CFG_PROCS_Z: r_pz   <= i_cfg_data[PROCS_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_axis_ld <= i_in.axis;
            r_slot    <= SLOT_W'(i_in.slot);
            r_cells   <= i_in.slab_cells;
            r_cx      <= i_in.coord_x;
            r_cy      <= i_in.coord_y;
            r_cz      <= i_in.coord_z;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sax   <= AXIS_X;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_go    <= 1'b0;
            r_nf    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (i_in.mode == MODE_QUERY) begin
                            r_state <= S_SCAN;
                            r_sax   <= AXIS_X;
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_nf    <= 1'b0;
                        end else if ((i_in.axis <= AXIS_Z) &&
                                     (PROCS_W'(i_in.slot) < PROCS_W'(MAX_PROCS))) begin
                            r_state <= S_LD_RD;
                        end
                    end
                end
                S_LD_RD: begin
                    r_state <= S_LD_WR;
                end
                S_LD_WR: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (w_adv) begin
                        if (w_miss_end) begin
                            r_nf <= 1'b1;
                        end
                        r_pend <= 1'b0;
                        r_idx  <= '0;
                        if (r_sax == w_last_axis) begin
                            r_state <= S_RANK;
                            r_go    <= 1'b1;
                        end else begin
                            r_sax <= r_sax + AXIS_W'(1);
                        end
                    end else begin
                        r_pend <= w_issue;
                        if (w_issue) begin
                            r_idx <= r_idx + PROCS_W'(1);
                        end
                    end
                end
                S_RANK: begin
                    if (w_rank_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // slab indices; inactive axes stay at zero
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sx <= '0;
            r_sy <= '0;
            r_sz <= '0;
        end else if (w_hit) begin
            case (r_sax)
                AXIS_X:  r_sx <= r_pidx;
                AXIS_Y:  r_sy <= r_pidx;
                AXIS_Z:  r_sz <= r_pidx;
                default: ;
            endcase
        end
        if (w_issue) begin
            r_pidx <= r_idx[SLOT_W-1:0];
        end
    end

    // output register, parts the result from the input side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_rank <= r_nf ? '0 : w_rank;
            r_out_nf   <= r_nf;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.owner_rank = r_out_rank;
    assign o_out.not_found  = r_out_nf;
endmodule
`default_nettype wire
